// ----- hdl/lkvc_pkg.sv -----
// ============================================================================
// lkvc_pkg
// Shared constants and types of the LRU key-value cache.
// ============================================================================
`timescale 1ns / 1ps

package lkvc_pkg;

   localparam int MAX_ENTRIES   = 16;
   localparam int KEY_BITS      = 32;
   localparam int VALUE_BITS    = 32;
   localparam int CAP_BITS      = 5;
   localparam int CAP_RESET     = 16;
   localparam int INDEX_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RANK_BITS     = INDEX_BITS;
   localparam int COUNT_BITS    = $clog2(MAX_ENTRIES + 1);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register indexes of the configuration port
   localparam logic [CSR_ADDR_BITS-3:0] REG_CAPACITY = '0;

   // operation codes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef logic signed [KEY_BITS-1:0]   key_type;
   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [INDEX_BITS-1:0]        index_type;
   typedef logic [RANK_BITS-1:0]         rank_type;
   typedef logic [COUNT_BITS-1:0]        count_type;
   typedef logic [CAP_BITS-1:0]          cap_type;
   typedef logic [CSR_ADDR_BITS-1:0]     csr_addr_type;
   typedef logic [CSR_DATA_BITS-1:0]     csr_data_type;

endpackage

// ----- hdl/lkvc_ram.sv -----
// ============================================================================
// lkvc_ram
// Generic single-port synchronous RAM with a registered read.
// ============================================================================
`timescale 1ns / 1ps

module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
   input  logic [WIDTH-1:0]                              wdata,
   output logic [WIDTH-1:0]                              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/lru_key_value_cache.sv -----
// ============================================================================
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// Result strobe: raised in the respond state that follows the lookup state, one cycle wide.
// A new item is refused in the lookup state, which launches the registered
// read of the value RAM; a new item is taken in the result cycle.
// Reset: synchronous; clears valid bits, ranks and occupancy, capacity = 16.
// Results cannot be stalled by the receiver.
// ============================================================================
`timescale 1ns / 1ps

module lru_key_value_cache (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_operation,
   input  lkvc_pkg::key_type     req_key,
   input  lkvc_pkg::value_type   req_value,
   // result channel
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output lkvc_pkg::value_type   rsp_read_value,
   output logic                  rsp_evicted,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  lkvc_pkg::csr_addr_type paddr,
   input  lkvc_pkg::csr_data_type pwdata,
   output lkvc_pkg::csr_data_type prdata,
   output logic                  pready
);

   import lkvc_pkg::*;

   // sequencer codes
   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_LOOKUP  = 2'd1;
   localparam logic [1:0] ST_RESPOND = 2'd2;

   logic [1:0] state_ff, state_in;

   // captured command
   logic      req_op_ff;
   key_type   req_key_ff;
   value_type req_value_ff;

   // tag side: keys, valid bits, recency ranks and fill count in flops
   key_type   key_store_ff [MAX_ENTRIES];
   logic      valid_ff     [MAX_ENTRIES];
   logic      valid_in     [MAX_ENTRIES];
   rank_type  rank_ff      [MAX_ENTRIES];
   rank_type  rank_in      [MAX_ENTRIES];
   count_type occ_ff, occ_in;
   cap_type   capacity_ff;

   // result flags
   logic rsp_hit_ff, rsp_evicted_ff, rsp_get_hit_ff;

   // lookup datapath
   logic      match     [MAX_ENTRIES];
   logic      evict_sel [MAX_ENTRIES];
   logic      keep      [MAX_ENTRIES];
   logic      hit;
   index_type found_idx;
   rank_type  found_rank;
   logic      slot_ok;
   index_type slot_idx;
   count_type cap_eff;
   count_type cap_less_one;
   logic      full;
   logic      key_wr_en;

   // value RAM port
   logic      ram_wr_en;
   index_type ram_addr;
   value_type ram_rdata;

   logic accept;
   logic csr_write;

   assign accept = start && !busy;
   assign busy   = (state_ff == ST_LOOKUP);

   // ------------------------------------------------------------------------
   // Configuration port: zero wait states, one register.
   // ------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[CSR_ADDR_BITS-1:2] == REG_CAPACITY)
                      ? CSR_DATA_BITS'(capacity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_BITS'(CAP_RESET);
      end else if (csr_write && (paddr[CSR_ADDR_BITS-1:2] == REG_CAPACITY)) begin
         capacity_ff <= pwdata[CAP_BITS-1:0];
      end
   end

   // Clamp capacity: zero acts as one, oversize saturates to the array depth.
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = COUNT_BITS'(1);
      end else if (int'(capacity_ff) > MAX_ENTRIES) begin
         cap_eff = COUNT_BITS'(MAX_ENTRIES);
      end else begin
         cap_eff = COUNT_BITS'(capacity_ff);
      end
   end

   assign cap_less_one = cap_eff - COUNT_BITS'(1);
   assign full         = (occ_ff >= cap_eff);

   // ------------------------------------------------------------------------
   // Sequencer: capture, look up and update, then present the result.
   // The result cycle already accepts the next item.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = accept ? ST_LOOKUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the command for the lookup cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_op_ff    <= req_operation;
         req_key_ff   <= req_key;
         req_value_ff <= req_value;
      end
   end

   // ------------------------------------------------------------------------
   // Parallel key match; the lowest matching entry wins.
   // ------------------------------------------------------------------------
   always_comb begin
      hit       = 1'b0;
      found_idx = '0;
      for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
         match[j] = valid_ff[j] && (key_store_ff[j] == req_key_ff);
         if (match[j]) begin
            hit       = 1'b1;
            found_idx = INDEX_BITS'(j);
         end
      end
   end

   assign found_rank = rank_ff[found_idx];

   // Ranks of valid entries form 0..occ-1, so dropping every rank at or past
   // capacity-1 leaves exactly one free place under the capacity.
   always_comb begin
      slot_ok  = 1'b0;
      slot_idx = '0;
      for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
         evict_sel[j] = full && valid_ff[j] && (COUNT_BITS'(rank_ff[j]) >= cap_less_one);
         keep[j]      = valid_ff[j] && !evict_sel[j];
         if (!keep[j]) begin
            slot_ok  = 1'b1;
            slot_idx = INDEX_BITS'(j);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Update of ranks, valid bits, fill count and the value RAM.
   // ------------------------------------------------------------------------
   always_comb begin
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         valid_in[j] = valid_ff[j];
         rank_in[j]  = rank_ff[j];
      end
      occ_in    = occ_ff;
      key_wr_en = 1'b0;
      ram_wr_en = 1'b0;
      ram_addr  = found_idx;

      if (state_ff == ST_LOOKUP) begin
         if (hit) begin
            // touch: younger entries age by one, the hit becomes the newest
            for (int j = 0; j < MAX_ENTRIES; j++) begin
               if (valid_ff[j] && (rank_ff[j] < found_rank)) begin
                  rank_in[j] = rank_ff[j] + RANK_BITS'(1);
               end
            end
            rank_in[found_idx] = '0;
            ram_wr_en          = (req_op_ff == OP_PUT);
         end else if (req_op_ff == OP_PUT) begin
            // drop the oldest entries if full, age the rest, insert newest
            for (int j = 0; j < MAX_ENTRIES; j++) begin
               if (evict_sel[j]) begin
                  valid_in[j] = 1'b0;
                  rank_in[j]  = '0;
               end else if (keep[j]) begin
                  rank_in[j] = rank_ff[j] + RANK_BITS'(1);
               end
            end
            occ_in   = full ? cap_less_one : occ_ff;
            ram_addr = slot_idx;
            if (slot_ok) begin
               valid_in[slot_idx] = 1'b1;
               rank_in[slot_idx]  = '0;
               occ_in             = occ_in + COUNT_BITS'(1);
               key_wr_en          = 1'b1;
               ram_wr_en          = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_ENTRIES; j++) begin
            valid_ff[j] <= 1'b0;
            rank_ff[j]  <= '0;
         end
         occ_ff <= '0;
      end else begin
         for (int j = 0; j < MAX_ENTRIES; j++) begin
            valid_ff[j] <= valid_in[j];
            rank_ff[j]  <= rank_in[j];
         end
         occ_ff <= occ_in;
      end
   end

   // Key store: written only at the insertion slot.
   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_store_ff[slot_idx] <= req_key_ff;
      end
   end

   lkvc_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_value_ram (
      .clock (clock),
      .wr_en (ram_wr_en),
      .addr  (ram_addr),
      .wdata (req_value_ff),
      .rdata (ram_rdata)
   );

   // ------------------------------------------------------------------------
   // Result: flags are set in the lookup cycle, the value arrives from the
   // RAM read launched in that same cycle.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOKUP) begin
         rsp_hit_ff     <= hit;
         rsp_get_hit_ff <= hit && (req_op_ff == OP_GET);
         rsp_evicted_ff <= !hit && (req_op_ff == OP_PUT) && full;
      end
   end

   assign rsp_valid      = (state_ff == ST_RESPOND);
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_read_value = rsp_get_hit_ff ? ram_rdata : '0;

endmodule

// ----- test/lru_key_value_cache_test.sv -----
// ============================================================================
// lru_key_value_cache_test
// Self-checking bench for the LRU key-value cache. Drives get and put
// commands, predicts each result with a behavioral LRU model kept in the
// bench, and compares every strobed result field by field. Directed items
// cover key and value extremes, update, miss, eviction, capacity zero, a
// capacity lowered below occupancy and an unmapped register. Random phases
// follow, each under its own capacity; all but the last idle in bursts.
// ============================================================================
`timescale 1ns / 1ps

module lru_key_value_cache_test;

   import lkvc_pkg::*;

   localparam int           LATENCY_CYCLES = 3;
   localparam csr_addr_type CAPACITY_ADDR  = {REG_CAPACITY, 2'b00};
   localparam csr_addr_type UNMAPPED_ADDR  = {~REG_CAPACITY, 2'b00};

   typedef struct packed {
      logic      hit;
      value_type read_value;
      logic      evicted;
   } cache_result_type;

   // ------------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // ------------------------------------------------------------------------
   logic         clock         = 1'b0;
   logic         reset         = 1'b1;
   logic         start         = 1'b0;
   logic         req_operation = OP_GET;
   key_type      req_key       = '0;
   value_type    req_value     = '0;
   logic         psel          = 1'b0;
   logic         penable       = 1'b0;
   logic         pwrite        = 1'b0;
   csr_addr_type paddr         = '0;
   csr_data_type pwdata        = '0;

   logic         busy;
   logic         rsp_valid;
   logic         rsp_hit;
   value_type    rsp_read_value;
   logic         rsp_evicted;
   csr_data_type prdata;
   logic         pready;

   always #4 clock = ~clock;

   lru_key_value_cache dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .rsp_evicted    (rsp_evicted),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // ------------------------------------------------------------------------
   // Bench copy of the cache: entries, recency ranks (0 = most recent),
   // occupancy and the capacity register as last written
   // ------------------------------------------------------------------------
   logic          cache_valid [MAX_ENTRIES];
   key_type       cache_key   [MAX_ENTRIES];
   value_type     cache_value [MAX_ENTRIES];
   int unsigned   cache_rank  [MAX_ENTRIES];
   int unsigned   cache_count;
   cap_type       cache_capacity;

   cache_result_type expected_results [$];
   int               error_count = 0;
   // 0 disables idling; n gives a one-in-n chance of a burst before an item
   int               gap_odds    = 0;

   // Work out the result of one command and advance the bench cache.
   function automatic cache_result_type predict_access(logic op, key_type k, value_type v);
      cache_result_type res;
      int               found;
      int               slot;
      int               oldest;
      int unsigned      limit;
      int unsigned      r;
      res   = '0;
      found = -1;
      slot  = -1;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         if (found < 0 && cache_valid[j] && cache_key[j] == k) begin
            found = j;
         end
      end
      if (found >= 0) begin
         res.hit = 1'b1;
         if (op == OP_PUT) begin
            cache_value[found] = v;
         end else begin
            res.read_value = cache_value[found];
         end
         // promote the entry; only those more recent than it age
         r = cache_rank[found];
         for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (cache_valid[j] && cache_rank[j] < r) begin
               cache_rank[j]++;
            end
         end
         cache_rank[found] = 0;
      end else if (op == OP_PUT) begin
         // zero acts as one, anything past the array saturates
         if (cache_capacity == 0) begin
            limit = 1;
         end else if (cache_capacity > MAX_ENTRIES) begin
            limit = MAX_ENTRIES;
         end else begin
            limit = 32'(cache_capacity);
         end
         // drop least recent entries until one slot is free under the limit
         while (cache_count >= limit) begin
            oldest = -1;
            for (int j = 0; j < MAX_ENTRIES; j++) begin
               if (cache_valid[j] && (oldest < 0 || cache_rank[j] > cache_rank[oldest])) begin
                  oldest = j;
               end
            end
            res.evicted = 1'b1;
            if (oldest < 0) begin
               break;
            end
            cache_valid[oldest] = 1'b0;
            cache_rank[oldest]  = 0;
            cache_count--;
         end
         for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (slot < 0 && !cache_valid[j]) begin
               slot = j;
            end
         end
         if (slot >= 0) begin
            for (int j = 0; j < MAX_ENTRIES; j++) begin
               if (cache_valid[j]) begin
                  cache_rank[j]++;
               end
            end
            cache_valid[slot] = 1'b1;
            cache_key[slot]   = k;
            cache_value[slot] = v;
            cache_rank[slot]  = 0;
            cache_count++;
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Command side. Every task returns just after a rising edge. start stays
   // high after an accepted item so that a following item goes out
   // back to back; an idle burst or a drain lowers it.
   // ------------------------------------------------------------------------
   task automatic send_command(logic op, key_type k, value_type v);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_key       <= k;
      req_value     <= v;
      // the item is taken at the first edge that sees busy low
      do @(posedge clock); while (busy !== 1'b0);
      expected_results.push_back(predict_access(op, k, v));
   endtask

   // Drop start and hold until every expected result has arrived.
   task automatic drain_results();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   // Two-phase register write; only the capacity address is mapped.
   // Release the bus and let an edge pass before returning.
   task automatic write_register(csr_addr_type addr, csr_data_type data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      if (addr == CAPACITY_ADDR) begin
         cache_capacity = data[CAP_BITS-1:0];
      end
   endtask

   // Read the capacity register back and compare with the bench copy.
   task automatic check_capacity_register();
      csr_data_type got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CAPACITY_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got[CAP_BITS-1:0] !== cache_capacity) begin
         $display("%0t: capacity readback expected %0d actual %0d",
                  $time, cache_capacity, got[CAP_BITS-1:0]);
         error_count++;
      end
   endtask

   // Set the capacity with random filler in the unused data bits.
   task automatic set_capacity(cap_type cap);
      csr_data_type data;
      data                 = $urandom;
      data[CAP_BITS-1:0]   = cap;
      write_register(CAPACITY_ADDR, data);
      check_capacity_register();
   endtask

   // ------------------------------------------------------------------------
   // Result side: the receiver cannot stall, so check each strobe against
   // the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      cache_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result expected none actual hit=%b value=%h evicted=%b",
                     $time, rsp_hit, rsp_read_value, rsp_evicted);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit expected %b actual %b", $time, want.hit, rsp_hit);
               error_count++;
            end
            if (rsp_read_value !== want.read_value) begin
               $display("%0t: read_value expected %h actual %h",
                        $time, want.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_evicted !== want.evicted) begin
               $display("%0t: evicted expected %b actual %b",
                        $time, want.evicted, rsp_evicted);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Capacity must come out of reset at its reset value.
   task automatic test_register_reset();
      check_capacity_register();
   endtask

   // Miss on empty, extreme keys and values, hits, update in place.
   task automatic test_extreme_keys();
      gap_odds = 3;
      send_command(OP_GET, 32'sh0000_0000, 32'sh1234_5678);
      send_command(OP_PUT, 32'sh8000_0000, 32'sh7fff_ffff);
      send_command(OP_PUT, 32'sh7fff_ffff, 32'sh8000_0000);
      send_command(OP_PUT, 32'shffff_ffff, 32'sh0000_0000);
      send_command(OP_PUT, 32'sh0000_0000, 32'shffff_ffff);
      send_command(OP_GET, 32'sh7fff_ffff, 32'sh5555_5555);
      send_command(OP_GET, 32'sh8000_0000, 32'shaaaa_aaaa);
      send_command(OP_GET, 32'sh0000_0000, 32'sh0000_0000);
      send_command(OP_GET, 32'shffff_ffff, 32'shffff_ffff);
      // overwrite a present key, then read the new value
      send_command(OP_PUT, 32'sh8000_0000, 32'sh0000_0001);
      send_command(OP_GET, 32'sh8000_0000, 32'sh0000_0000);
      send_command(OP_GET, 32'sh0000_0001, 32'sh0000_0000);
      drain_results();
   endtask

   // Drop the capacity under the occupancy: the next new key evicts
   // several entries at once, later ones evict the least recent.
   task automatic test_lowered_capacity();
      set_capacity(5'd2);
      send_command(OP_PUT, 32'sh0000_0a0a, 32'sh0000_0001);
      send_command(OP_PUT, 32'sh0000_0b0b, 32'sh0000_0002);
      send_command(OP_GET, 32'sh0000_0a0a, 32'sh0000_0000);
      send_command(OP_PUT, 32'sh0000_0c0c, 32'sh0000_0003);
      send_command(OP_GET, 32'sh0000_0b0b, 32'sh0000_0000);
      drain_results();
   endtask

   // Capacity zero behaves as a single entry.
   task automatic test_capacity_zero();
      set_capacity(5'd0);
      send_command(OP_PUT, 32'sh0101_0101, 32'sh1111_1111);
      send_command(OP_PUT, 32'sh0202_0202, 32'sh2222_2222);
      send_command(OP_GET, 32'sh0101_0101, 32'sh0000_0000);
      send_command(OP_GET, 32'sh0202_0202, 32'sh0000_0000);
      drain_results();
   endtask

   // A write to an unmapped address must leave the capacity alone.
   task automatic test_unmapped_register();
      write_register(UNMAPPED_ADDR, $urandom);
      check_capacity_register();
      send_command(OP_PUT, 32'sh0303_0303, 32'sh3333_3333);
      drain_results();
   endtask

   // One random phase under one capacity. Keys come mostly from a pool a
   // little larger than the capacity so that hits, updates and evictions
   // all happen; the rest are fresh random keys.
   task automatic run_random_phase(cap_type cap, int count, bit with_gaps);
      key_type     key_pool [$];
      int unsigned pool_size;
      key_type     k;
      drain_results();
      set_capacity(cap);
      pool_size = ((cap == 0) ? 1 : (cap > MAX_ENTRIES) ? MAX_ENTRIES : cap)
                  + $urandom_range(1, 4);
      repeat (pool_size) key_pool.push_back($urandom);
      gap_odds = 0;
      for (int n = 0; n < count; n++) begin
         // alternate stretches with and without idle bursts
         if (n % 40 == 0) begin
            gap_odds = (with_gaps && $urandom_range(0, 2) != 0) ? $urandom_range(2, 5) : 0;
         end
         if ($urandom_range(0, 9) == 0) begin
            k = $urandom;
         end else begin
            k = key_pool[$urandom_range(0, pool_size - 1)];
         end
         send_command(1'($urandom_range(0, 1)), k, $urandom);
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(5'd16, 123, 1'b1);
      run_random_phase(5'd1,  123, 1'b1);
      run_random_phase(5'd31, 123, 1'b1);
      run_random_phase(5'd3,  123, 1'b1);
      run_random_phase(5'd0,  123, 1'b1);
      run_random_phase(5'd8,  123, 1'b1);
      run_random_phase(5'd17, 123, 1'b1);
      run_random_phase(5'd5,  123, 1'b1);
      run_random_phase(5'd2,  123, 1'b1);
      // close at full speed, no idling
      run_random_phase(5'd12, 123, 1'b0);
      drain_results();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         cache_valid[j] = 1'b0;
         cache_key[j]   = '0;
         cache_value[j] = '0;
         cache_rank[j]  = 0;
      end
      cache_count    = 0;
      cache_capacity = CAP_BITS'(CAP_RESET);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_reset();
      test_extreme_keys();
      test_lowered_capacity();
      test_capacity_zero();
      test_unmapped_register();
      test_random_traffic();

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hold a hard limit far beyond the slowest correct run.
   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

endmodule
